@@ design/u8nc_pkg.sv @@
`default_nettype none
package u8nc_pkg;

  localparam int CpW  = 21;
  localparam int LenW = 3;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NUL      = 3'd1,
    ST_BAD_LEAD = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_BAD_CONT = 3'd4
  } status_t;

  // One decode step's outcome
  typedef struct packed {
    logic             emit;
    status_t          status;
    logic [CpW-1:0]   code_point;
    logic [LenW-1:0]  seq_length;
  } res_t;

endpackage
`default_nettype wire

@@ design/utf8_decoder_xml_name_class.sv @@
// A byte accepted into the input register passes one decode step; its result is written to
// the result register, raising m_axis_tvalid, when that register can take a beat.
// Throughput: one byte per cycle while the result register can take a beat.
// Lead and middle bytes of a multibyte sequence give no result beat.
// Reset (rst, synchronous, active high) empties both registers and returns the
// decoder to waiting for a lead byte.
`default_nettype none
module utf8_decoder_xml_name_class
  import u8nc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // data_byte[7:0], bytes_remaining[10:8], zero pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // code_point[20:0], seq_length[23:21]
  output logic [4:0]       m_axis_tuser   // status[2:0], name_start_ok[3], name_char_ok[4]
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic [2:0] in_avail;
  logic       advance;

  res_t       res;
  logic       ns_ok;
  logic       nc_ok;

  logic           out_valid;
  logic [CpW-1:0] out_cp;
  logic [2:0]     out_len;
  status_t        out_status;
  logic           out_ns;
  logic           out_nc;

  // Step the decoder when a byte is held and the result register can take a beat
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte  <= s_axis_tdata[7:0];
      in_avail <= s_axis_tdata[10:8];
    end
  end

  u8nc_step u_step (
    .clk             (clk),
    .rst             (rst),
    .fire            (advance),
    .data_byte       (in_byte),
    .bytes_remaining (in_avail),
    .res             (res)
  );

  u8nc_class u_class (
    .code_point    (res.code_point),
    .valid_cp      (res.status == ST_OK),
    .name_start_ok (ns_ok),
    .name_char_ok  (nc_ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.emit;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_cp     <= res.code_point;
      out_len    <= res.seq_length;
      out_status <= res.status;
      out_ns     <= ns_ok;
      out_nc     <= nc_ok;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_len, out_cp};
  assign m_axis_tuser  = {out_nc, out_ns, out_status};

  a_err_zero : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_status != ST_OK) |-> (out_cp == '0) && (out_len == 3'd0))
    else $error("error beat carries a code point or length");

  a_start_is_char : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_ns |-> out_nc)
    else $error("name start character not flagged as name character");

  a_ok_len : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_status == ST_OK) |->
      (out_len == 3'd1) || (out_len == 3'd2) || (out_len == 3'd3) || (out_len == 3'd4))
    else $error("ok beat with bad sequence length");

  a_no_beat_without_step : assert property (@(posedge clk) disable iff (rst)
    !$past(m_axis_tvalid) && !$past(advance) && !$past(rst) |-> !m_axis_tvalid)
    else $error("result appeared without a decode step");

endmodule
`default_nettype wire

@@ design/u8nc_step.sv @@
`default_nettype none
module u8nc_step
  import u8nc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] data_byte,
  input  wire logic [2:0] bytes_remaining,
  output res_t            res
);

  logic [1:0]     bytes_pending, bytes_pending_next;
  logic [CpW-1:0] partial_value, partial_value_next;
  logic [2:0]     sequence_size, sequence_size_next;

  logic [CpW-1:0] shifted;
  logic [2:0]     need;
  logic [1:0]     need_m1;
  logic [CpW-1:0] lead_bits;
  logic           is_lead;

  assign shifted = {partial_value[CpW-7:0], data_byte[5:0]};

  always_comb begin
    need      = 3'd2;
    need_m1   = 2'd1;
    lead_bits = '0;
    is_lead   = 1'b1;
    priority if (data_byte[7:5] == 3'b110) begin
      need      = 3'd2;
      need_m1   = 2'd1;
      lead_bits = CpW'(data_byte[4:0]);
    end else if (data_byte[7:4] == 4'b1110) begin
      need      = 3'd3;
      need_m1   = 2'd2;
      lead_bits = CpW'(data_byte[3:0]);
    end else if (data_byte[7:3] == 5'b11110) begin
      need      = 3'd4;
      need_m1   = 2'd3;
      lead_bits = CpW'(data_byte[2:0]);
    end else begin
      is_lead = 1'b0;
    end
  end

  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_value_next = partial_value;
    sequence_size_next = sequence_size;
    res                = '0;
    res.status         = ST_OK;
    if (bytes_pending != 2'd0) begin
      if (data_byte[7:6] != 2'b10) begin
        bytes_pending_next = 2'd0;
        partial_value_next = '0;
        sequence_size_next = 3'd0;
        res.emit           = 1'b1;
        res.status         = ST_BAD_CONT;
      end else if (bytes_pending == 2'd1) begin
        bytes_pending_next = 2'd0;
        partial_value_next = '0;
        sequence_size_next = 3'd0;
        res.emit           = 1'b1;
        res.code_point     = shifted;
        res.seq_length     = sequence_size;
      end else begin
        bytes_pending_next = bytes_pending - 2'd1;
        partial_value_next = shifted;
      end
    end else begin
      priority if (data_byte == 8'd0) begin
        res.emit   = 1'b1;
        res.status = ST_NUL;
      end else if (!data_byte[7]) begin
        res.emit       = 1'b1;
        res.code_point = CpW'(data_byte);
        res.seq_length = 3'd1;
      end else if (!is_lead) begin
        res.emit   = 1'b1;
        res.status = ST_BAD_LEAD;
      end else if (bytes_remaining < need) begin
        partial_value_next = '0;
        sequence_size_next = 3'd0;
        res.emit           = 1'b1;
        res.status         = ST_TRUNC;
      end else begin
        bytes_pending_next = need_m1;
        partial_value_next = lead_bits;
        sequence_size_next = need;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      partial_value <= '0;
      sequence_size <= 3'd0;
    end else if (fire) begin
      bytes_pending <= bytes_pending_next;
      partial_value <= partial_value_next;
      sequence_size <= sequence_size_next;
    end
  end

endmodule
`default_nettype wire

@@ design/u8nc_class.sv @@
`default_nettype none
module u8nc_class
  import u8nc_pkg::*;
(
  input  wire logic [CpW-1:0] code_point,
  input  wire logic           valid_cp,
  output logic                name_start_ok,
  output logic                name_char_ok
);

  function automatic logic in_span(input logic [CpW-1:0] v, input logic [CpW-1:0] lo,
                                   input logic [CpW-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  logic start_hit;
  logic extra_hit;

  always_comb begin
    start_hit = (code_point == 21'h3A) || in_span(code_point, 21'h41, 21'h5A) ||
                (code_point == 21'h5F) || in_span(code_point, 21'h61, 21'h7A) ||
                in_span(code_point, 21'hC0, 21'hD6) || in_span(code_point, 21'hD8, 21'hF6) ||
                in_span(code_point, 21'hF8, 21'h2FF) ||
                in_span(code_point, 21'h370, 21'h37D) ||
                in_span(code_point, 21'h37F, 21'h1FFF) ||
                in_span(code_point, 21'h200C, 21'h200D) ||
                in_span(code_point, 21'h2070, 21'h218F) ||
                in_span(code_point, 21'h2C00, 21'h2FEF) ||
                in_span(code_point, 21'h3001, 21'hD7FF) ||
                in_span(code_point, 21'hF900, 21'hFDCF) ||
                in_span(code_point, 21'hFDF0, 21'hFFFD) ||
                in_span(code_point, 21'h10000, 21'hEFFFF);
    extra_hit = (code_point == 21'h2D) || (code_point == 21'h2E) ||
                in_span(code_point, 21'h30, 21'h39) || (code_point == 21'hB7) ||
                in_span(code_point, 21'h300, 21'h36F) ||
                in_span(code_point, 21'h203F, 21'h2040);
    name_start_ok = valid_cp && start_hit;
    name_char_ok  = valid_cp && (start_hit || extra_hit);
  end

endmodule
`default_nettype wire

@@ tb/utf8_name_checker.sv @@
`timescale 1ns / 1ps
module utf8_name_checker
  import u8nc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // data_byte[7:0], bytes_remaining[10:8], zero pad
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [23:0] m_axis_tdata,  // code_point[20:0], seq_length[23:21]
  input  wire logic [4:0]  m_axis_tuser,  // status[2:0], name_start_ok[3], name_char_ok[4]
  output int               fail_count,
  output int               chars_waiting,
  output int               chars_checked
);

  typedef struct packed {
    logic [CpW-1:0]  code_point;
    logic [LenW-1:0] seq_length;
    status_t         status;
    logic            name_start;
    logic            name_char;
  } char_res_t;

  char_res_t      expected_chars [$];
  logic [1:0]     cont_left = 2'd0;
  logic [CpW-1:0] acc_value = '0;
  logic [2:0]     seq_bytes = 3'd0;
  int             fails     = 0;
  int             checked   = 0;

  function automatic logic in_span(logic [CpW-1:0] v, int unsigned lo, int unsigned hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic logic xml_start(logic [CpW-1:0] v);
    return v == 'h3A || in_span(v, 'h41, 'h5A) || v == 'h5F || in_span(v, 'h61, 'h7A) ||
           in_span(v, 'hC0, 'hD6) || in_span(v, 'hD8, 'hF6) || in_span(v, 'hF8, 'h2FF) ||
           in_span(v, 'h370, 'h37D) || in_span(v, 'h37F, 'h1FFF) ||
           in_span(v, 'h200C, 'h200D) || in_span(v, 'h2070, 'h218F) ||
           in_span(v, 'h2C00, 'h2FEF) || in_span(v, 'h3001, 'hD7FF) ||
           in_span(v, 'hF900, 'hFDCF) || in_span(v, 'hFDF0, 'hFFFD) ||
           in_span(v, 'h10000, 'hEFFFF);
  endfunction

  function automatic logic xml_name(logic [CpW-1:0] v);
    return xml_start(v) || v == 'h2D || v == 'h2E || in_span(v, 'h30, 'h39) ||
           v == 'hB7 || in_span(v, 'h300, 'h36F) || in_span(v, 'h203F, 'h2040);
  endfunction

  // Advance the decoder by one byte; produced is low for lead and middle bytes.
  task automatic decode_byte(input logic [7:0] b, input logic [2:0] rem,
                             output logic produced, output char_res_t r);
    logic [2:0] need;
    produced = 1'b1;
    r        = '0;
    need     = 3'd0;
    if (cont_left != 2'd0) begin
      if (b[7:6] != 2'b10) begin
        cont_left = 2'd0;
        acc_value = '0;
        seq_bytes = 3'd0;
        r.status  = ST_BAD_CONT;
      end else begin
        acc_value = {acc_value[CpW-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left != 2'd0) begin
          produced = 1'b0;
        end else begin
          r.status     = ST_OK;
          r.code_point = acc_value;
          r.seq_length = seq_bytes;
          acc_value    = '0;
          seq_bytes    = 3'd0;
        end
      end
    end else if (b == 8'h00) begin
      r.status = ST_NUL;
    end else if (!b[7]) begin
      r.status     = ST_OK;
      r.code_point = {13'd0, b};
      r.seq_length = 3'd1;
    end else begin
      if (b[7:5] == 3'b110) begin
        need      = 3'd2;
        acc_value = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        need      = 3'd3;
        acc_value = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        need      = 3'd4;
        acc_value = {18'd0, b[2:0]};
      end
      if (need == 3'd0) begin
        r.status = ST_BAD_LEAD;
      end else if (rem < need) begin
        acc_value = '0;
        seq_bytes = 3'd0;
        r.status  = ST_TRUNC;
      end else begin
        seq_bytes = need;
        cont_left = need[1:0] - 2'd1;
        produced  = 1'b0;
      end
    end
    if (produced && r.status == ST_OK) begin
      r.name_start = xml_start(r.code_point);
      r.name_char  = xml_name(r.code_point);
    end
  endtask

  task automatic check_field(input string fname, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin : track
    char_res_t want;
    char_res_t got;
    logic      produced;
    if (rst) begin
      expected_chars.delete();
      cont_left = 2'd0;
      acc_value = '0;
      seq_bytes = 3'd0;
    end else begin
      // Pop before push: a result never leaves in the edge its byte enters.
      if (m_axis_tvalid && m_axis_tready) begin
        got.code_point = m_axis_tdata[20:0];
        got.seq_length = m_axis_tdata[23:21];
        got.status     = status_t'(m_axis_tuser[2:0]);
        got.name_start = m_axis_tuser[3];
        got.name_char  = m_axis_tuser[4];
        if (expected_chars.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, actual cp %0h status %0d",
                   $time, got.code_point, got.status);
          fails++;
        end else begin
          want = expected_chars.pop_front();
          check_field("code_point", want.code_point, got.code_point);
          check_field("seq_length", want.seq_length, got.seq_length);
          check_field("status", want.status, got.status);
          check_field("name_start_ok", want.name_start, got.name_start);
          check_field("name_char_ok", want.name_char, got.name_char);
          checked++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata[7:0], s_axis_tdata[10:8], produced, want);
        if (produced) expected_chars.push_back(want);
      end
    end
    chars_waiting <= expected_chars.size();
    fail_count    <= fails;
    chars_checked <= checked;
  end

endmodule

@@ tb/utf8_decoder_xml_name_class_tb.sv @@
`timescale 1ns / 1ps
module utf8_decoder_xml_name_class_tb;

  localparam int StallLimit = 3000;
  localparam int HoldCycles = 400;

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = 16'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [4:0]  m_axis_tuser;

  int fail_count;
  int chars_waiting;
  int chars_checked;
  int bytes_sent  = 0;
  int tx_idle_pct = 14;
  int rx_idle_pct = 73;
  logic rx_hold   = 1'b0;
  logic hold_req  = 1'b0;
  int stall_count = 0;

  // Spans and singletons of the XML name classes; neighbors are reached by offset.
  int unsigned class_bounds [0:39] = '{
    'h2D, 'h2E, 'h30, 'h39, 'h3A, 'h41, 'h5A, 'h5F, 'h61, 'h7A,
    'hB7, 'hC0, 'hD6, 'hD8, 'hF6, 'hF8, 'h2FF, 'h300, 'h36F, 'h370,
    'h37D, 'h37F, 'h1FFF, 'h200C, 'h200D, 'h203F, 'h2040, 'h2070, 'h218F, 'h2C00,
    'h2FEF, 'h3001, 'hD7FF, 'hF900, 'hFDCF, 'hFDF0, 'hFFFD, 'h10000, 'hEFFFF, 'h1FFFFF
  };

  utf8_decoder_xml_name_class u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  utf8_name_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_count   (fail_count),
    .chars_waiting(chars_waiting),
    .chars_checked(chars_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rx_hold) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Long receiver hold-off so the input side backs up.
  initial begin
    while (!hold_req) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
    end
    if (stall_count >= StallLimit) begin
      $display("%0t: no beat moved for %0d cycles", $time, StallLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic [2:0] rem);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, rem, b};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  function automatic logic [7:0] lead_byte(input int len, input logic [20:0] cp);
    case (len)
      1:       return {1'b0, cp[6:0]};
      2:       return {3'b110, cp[10:6]};
      3:       return {4'b1110, cp[15:12]};
      default: return {5'b11110, cp[20:18]};
    endcase
  endfunction

  task automatic send_char(input logic [20:0] cp, input int len, input logic [2:0] rem);
    send_beat(lead_byte(len, cp), rem);
    for (int k = len - 2; k >= 0; k--) send_beat({2'b10, cp[6*k +: 6]}, 3'($urandom_range(7)));
  endtask

  // Hold the input idle until every predicted result has drained.
  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (chars_waiting != 0) @(posedge clk);
  endtask

  task automatic send_random_unit();
    int         kind;
    int         len;
    int         lmin;
    int         v;
    int         good;
    logic [7:0] b;
    kind = $urandom_range(99);
    if (kind < 60) begin
      if ($urandom_range(1) == 1) begin
        v = int'(class_bounds[$urandom_range(39)]) + int'($urandom_range(2)) - 1;
        if (v > 'h1FFFFF) v = 'h1FFFFF;
        lmin = (v < 'h80) ? 1 : (v < 'h800) ? 2 : (v < 'h10000) ? 3 : 4;
        len  = $urandom_range(4, lmin);
      end else begin
        len = $urandom_range(4, 1);
        case (len)
          1:       v = $urandom_range('h7F);
          2:       v = $urandom_range('h7FF);
          3:       v = $urandom_range('hFFFF);
          default: v = $urandom_range('h1FFFFF);
        endcase
      end
      send_char(v[20:0], len, 3'($urandom_range(7, len)));
    end else if (kind < 75) begin
      // lead byte with too few bytes left in the buffer
      len = $urandom_range(4, 2);
      send_beat(lead_byte(len, 21'($urandom)), 3'($urandom_range(len - 1, 0)));
    end else if (kind < 85) begin
      // sequence broken by a byte without the continuation mark
      len  = $urandom_range(4, 2);
      good = $urandom_range(len - 2, 0);
      send_beat(lead_byte(len, 21'($urandom)), 3'($urandom_range(7, len)));
      repeat (good) send_beat({2'b10, 6'($urandom_range(63))}, 3'($urandom_range(7)));
      b = 8'($urandom_range(255));
      if (b[7:6] == 2'b10) b[7] = 1'b0;
      send_beat(b, 3'($urandom_range(7)));
    end else begin
      send_beat(8'($urandom_range(255)), 3'($urandom_range(7)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: NUL, ASCII ends, bad leads, each length, truncation, broken runs.
    send_beat(8'h00, 3'd1);
    send_beat(8'h41, 3'd0);
    send_beat(8'h7F, 3'd4);
    send_beat(8'h80, 3'd4);
    send_beat(8'hFF, 3'd4);
    send_beat(8'hF8, 3'd7);
    send_char(21'h0000E9, 2, 3'd2);
    send_char(21'h000000, 2, 3'd5);
    send_char(21'h00203F, 3, 3'd3);
    send_char(21'h1FFFFF, 4, 3'd7);
    send_beat(8'hC3, 3'd1);
    send_beat(8'hF0, 3'd0);
    send_beat(8'hE2, 3'd2);
    send_beat(8'hE2, 3'd6);
    send_beat(8'h41, 3'd4);
    send_beat(8'hC3, 3'd4);
    send_beat(8'h00, 3'd3);
    wait_results_done();

    while (bytes_sent < 600) send_random_unit();
    wait_results_done();

    tx_idle_pct = 73;
    rx_idle_pct <= 14;
    while (bytes_sent < 1200) send_random_unit();
    wait_results_done();

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_req    <= 1'b1;
    while (bytes_sent < 1800) send_random_unit();
    wait_results_done();
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes under three backpressure mixes and one long output stall;",
             bytes_sent);
    $display("checked %0d decode results over every status and XML name class edge.",
             chars_checked);
    if (fail_count == 0 && chars_waiting == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
